@@ sv/asge_pkg.sv @@
// Shared constants, codes and pipeline payload types for the gas exchange step.
`timescale 1ns / 1ps
package asge_pkg;

  // Number of mixed layers summed into the exchange depth
  localparam int MIXED_LAYERS = 2;
  // Largest programmable substep count, one unrolled substep each
  localparam int NUM_SUBSTEPS = 63;

  // Internal widths, set by the field ranges
  localparam int DEPTH_W = 25;   // sum of two Q16.8 thicknesses
  localparam int TGT_W   = 33;   // saturation * pressure, Q.24
  localparam int KE_W    = 32;   // open-water piston velocity, Q.40
  localparam int SC_W    = 53;   // positive Schmidt number, Q.16
  localparam int Q_W     = 58;   // 660 * 2^48 / Sc
  localparam int G_W     = 29;   // floor square root of the above
  localparam int KG_W    = 37;   // kg, Q.32
  localparam int N_W     = 69;   // kg * dt
  localparam int ALPHA_W = 36;   // relaxation factor, Q.32
  localparam int DIFF_W  = 35;   // target - concentration

  localparam int QLO_W   = ALPHA_W;  // dividend bits shifted into the depth divider
  localparam int ROOT_REM_W = G_W + 2;

  // Dividend of the Schmidt scale division
  localparam logic [Q_W-1:0] SC_NUM = Q_W'(660) << 48;

  localparam logic [5:0] SUBSTEPS_RESET = 6'd30;

  // Configuration register indexes
  localparam logic [2:0] REG_A0     = 3'd0;
  localparam logic [2:0] REG_A1     = 3'd1;
  localparam logic [2:0] REG_A2     = 3'd2;
  localparam logic [2:0] REG_A3     = 3'd3;
  localparam logic [2:0] REG_DT     = 3'd4;
  localparam logic [2:0] REG_COUNT  = 3'd5;

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_LAND    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Fields carried through the front of the pipeline
  typedef struct packed {
    logic [KE_W-1:0]    ke;
    logic [DEPTH_W-1:0] depth;
    logic [TGT_W-1:0]   target;
    logic [31:0]        conc;
    status_e            status;
  } side_t;

  // Fields carried through the substep chain
  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [TGT_W-1:0]   target;
    logic [31:0]        conc;
    status_e            status;
  } step_t;

endpackage

@@ sv/air_sea_gas_exchange_step.sv @@
// Top level: air-sea gas exchange for one ocean grid cell per cycle when not stalled.
//
// Input channel: in_valid_i with in_stall_o; one grid cell is transferred at
// a clock edge where in_valid_i is high and in_stall_o is low. Output channel:
// out_valid_o with out_stall_i; one result per cell, in order.
// Configuration: cfg_we_i, cfg_addr_i, cfg_wdata_i write the Schmidt
// coefficients, substep length and substep count; write only while idle.
// Pipeline: from the input transfer to the result in the output register there are
// 4 Schmidt/multiply stages, 58 stages of the Schmidt division, 29 square root
// stages, 3 multiply stages, 1 saturation check, 36 stages of the depth division
// and 2 stages for each of the 63 unrolled substeps.
// Throughput: one cell per cycle while the output stall does not hold the pipeline;
// every stage is a register stage of the single pipeline, and substeps beyond substep_count pass values through.
// Reset: clears all valid bits and the configuration registers (substep count to 30).
// Stall: while out_valid_o is high and out_stall_i is high the whole pipeline
// holds, and in_stall_o is raised in the same cycle; nothing is dropped.
`timescale 1ns / 1ps
module air_sea_gas_exchange_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        is_ocean_i,
  input  logic signed [31:0] concentration_i,
  input  logic signed [14:0] temperature_i,
  input  logic [30:0] saturation_i,
  input  logic [16:0] ice_fraction_i,
  input  logic [31:0] piston_velocity_i,
  input  logic [17:0] air_pressure_i,
  input  logic [23:0] layer_depth_top_i,
  input  logic [23:0] layer_depth_second_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] new_concentration_o,
  output logic [1:0]  status_o
);
  import asge_pkg::*;

  logic en;

  // configuration registers
  logic [31:0] a0_q, a1_q, a2_q, a3_q, dt_q;
  logic [5:0]  cnt_q;

  // stage 1
  logic        s1_valid_q;
  side_t       s1_side_q;
  logic        s1_tneg_q;
  logic [14:0] s1_tmag_q;
  logic [29:0] s1_t2_q;
  side_t       s1_side_d;
  logic [14:0] tmag;
  logic [16:0] open_frac;
  logic [48:0] ke_prod;
  logic [48:0] tgt_prod;

  // stage 2
  logic        s2_valid_q;
  side_t       s2_side_q;
  logic        s2_tneg_q;
  logic [14:0] s2_tmag_q;
  logic [38:0] s2_p1_q;
  logic [45:0] s2_p2_q;
  logic [45:0] s2_p3_q;
  logic [46:0] p1;
  logic [61:0] p2;
  logic [61:0] p3;

  // stage 3
  logic        s3_valid_q;
  side_t       s3_side_q;
  logic        s3_tneg_q;
  logic [46:0] s3_even_q;
  logic [38:0] s3_p1_q;
  logic [52:0] s3_p3_q;
  logic [60:0] p3b;

  // stage 4
  logic        s4_valid_q;
  side_t       s4_side_q;
  logic [SC_W-1:0] s4_sc_q;
  logic [53:0] odd;
  logic signed [55:0] sc;
  side_t       s4_side_d;

  // Schmidt scale division
  logic            d1_valid_q [Q_W];
  side_t           d1_side_q  [Q_W];
  logic [SC_W-1:0] d1_sc_q    [Q_W];
  logic [SC_W-1:0] d1_rem_q   [Q_W];
  logic [Q_W-1:0]  d1_quo_q   [Q_W];

  // square root
  logic                  sq_valid_q [G_W];
  side_t                 sq_side_q  [G_W];
  logic [Q_W-1:0]        sq_rad_q   [G_W];
  logic [ROOT_REM_W-1:0] sq_rem_q   [G_W];
  logic [G_W-1:0]        sq_root_q  [G_W];

  // transfer factor multiplies
  logic             m1_valid_q;
  side_t            m1_side_q;
  logic [KG_W-1:0]  m1_kg_q;
  logic [60:0]      kg_prod;
  logic             m2_valid_q;
  side_t            m2_side_q;
  logic [63:0]      m2_nlo_q;
  logic [36:0]      m2_nhi_q;
  logic             m3_valid_q;
  side_t            m3_side_q;
  logic [N_W-1:0]   m3_n_q;

  // saturation check
  logic               d0_valid_q;
  side_t              d0_side_q;
  logic               d0_sat_q;
  logic [DEPTH_W-1:0] d0_rem_q;
  logic [QLO_W-1:0]   d0_low_q;

  // depth division
  logic               d2_valid_q [QLO_W];
  side_t              d2_side_q  [QLO_W];
  logic               d2_sat_q   [QLO_W];
  logic [DEPTH_W-1:0] d2_rem_q   [QLO_W];
  logic [QLO_W-1:0]   d2_low_q   [QLO_W];
  logic [ALPHA_W-1:0] d2_quo_q   [QLO_W];

  // substep chain
  logic  st_valid [NUM_SUBSTEPS+1];
  step_t st_data  [NUM_SUBSTEPS+1];

  // Whole pipeline advances unless a finished result is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_q  <= '0;
      a1_q  <= '0;
      a2_q  <= '0;
      a3_q  <= '0;
      dt_q  <= '0;
      cnt_q <= SUBSTEPS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_A0:    a0_q  <= cfg_wdata_i;
        REG_A1:    a1_q  <= cfg_wdata_i;
        REG_A2:    a2_q  <= cfg_wdata_i;
        REG_A3:    a3_q  <= cfg_wdata_i;
        REG_DT:    dt_q  <= cfg_wdata_i;
        REG_COUNT: cnt_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Stage 1: temperature magnitude and square, open water, target, depth
  assign tmag      = temperature_i[14] ? 15'(-temperature_i) : 15'(temperature_i);
  assign open_frac = (ice_fraction_i > 17'd65536) ? 17'd0 : 17'(17'd65536 - ice_fraction_i);
  assign ke_prod   = 49'(open_frac) * 49'(piston_velocity_i);
  assign tgt_prod  = 49'(saturation_i) * 49'(air_pressure_i);

  always_comb begin
    s1_side_d.ke     = ke_prod[47:16];
    s1_side_d.target = tgt_prod[48:16];
    s1_side_d.conc   = concentration_i;
    s1_side_d.status = is_ocean_i ? ST_UPDATED : ST_LAND;
    if (MIXED_LAYERS > 1) begin
      s1_side_d.depth = DEPTH_W'(layer_depth_top_i) + DEPTH_W'(layer_depth_second_i);
    end else begin
      s1_side_d.depth = DEPTH_W'(layer_depth_top_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= s1_side_d;
      s1_tneg_q <= temperature_i[14];
      s1_tmag_q <= tmag;
      s1_t2_q   <= 30'(tmag) * 30'(tmag);
    end
  end

  // Stage 2: polynomial products
  assign p1 = 47'(a1_q) * 47'(s1_tmag_q);
  assign p2 = 62'(a2_q) * 62'(s1_t2_q);
  assign p3 = 62'(a3_q) * 62'(s1_t2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= s1_side_q;
      s2_tneg_q <= s1_tneg_q;
      s2_tmag_q <= s1_tmag_q;
      s2_p1_q   <= p1[46:8];
      s2_p2_q   <= p2[61:16];
      s2_p3_q   <= p3[61:16];
    end
  end

  // Stage 3: even part, cubic term times |T|
  assign p3b = 61'(s2_p3_q) * 61'(s2_tmag_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q <= s2_side_q;
      s3_tneg_q <= s2_tneg_q;
      s3_even_q <= 47'(a0_q) + 47'(s2_p2_q);
      s3_p1_q   <= s2_p1_q;
      s3_p3_q   <= p3b[60:8];
    end
  end

  // Stage 4: odd part sign, Schmidt number and validity
  assign odd = 54'(s3_p1_q) + 54'(s3_p3_q);
  assign sc  = s3_tneg_q ? $signed(56'(s3_even_q)) + $signed(56'(odd))
                         : $signed(56'(s3_even_q)) - $signed(56'(odd));

  always_comb begin
    s4_side_d = s3_side_q;
    if (s3_side_q.status == ST_UPDATED &&
        (s3_side_q.depth == '0 || sc[55] || sc == '0)) begin
      s4_side_d.status = ST_INVALID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_side_q <= s4_side_d;
      s4_sc_q   <= sc[SC_W-1:0];
    end
  end

  // Restoring division 660 * 2^48 / Sc, one quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_div1
    logic            v_in;
    side_t           side_in;
    logic [SC_W-1:0] sc_in;
    logic [SC_W-1:0] rem_in;
    logic [Q_W-1:0]  quo_in;
    logic [SC_W:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign v_in    = s4_valid_q;
      assign side_in = s4_side_q;
      assign sc_in   = s4_sc_q;
      assign rem_in  = '0;
      assign quo_in  = '0;
    end else begin : g_next
      assign v_in    = d1_valid_q[k-1];
      assign side_in = d1_side_q[k-1];
      assign sc_in   = d1_sc_q[k-1];
      assign rem_in  = d1_rem_q[k-1];
      assign quo_in  = d1_quo_q[k-1];
    end

    assign trial = {rem_in, SC_NUM[Q_W-1-k]};
    assign take  = trial >= {1'b0, sc_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d1_valid_q[k] <= 1'b0;
      end else if (en) begin
        d1_valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d1_side_q[k] <= side_in;
        d1_sc_q[k]   <= sc_in;
        d1_rem_q[k]  <= take ? SC_W'(trial - {1'b0, sc_in}) : SC_W'(trial);
        d1_quo_q[k]  <= {quo_in[Q_W-2:0], take};
      end
    end
  end

  // Floor square root, one root bit per stage
  for (genvar j = 0; j < G_W; j++) begin : g_sqrt
    localparam int PI = G_W - 1 - j;
    logic                  v_in;
    side_t                 side_in;
    logic [Q_W-1:0]        rad_in;
    logic [ROOT_REM_W-1:0] rem_in;
    logic [G_W-1:0]        root_in;
    logic [ROOT_REM_W+1:0] cur;
    logic [ROOT_REM_W+1:0] trial;
    logic                  take;

    if (j == 0) begin : g_first
      assign v_in    = d1_valid_q[Q_W-1];
      assign side_in = d1_side_q[Q_W-1];
      assign rad_in  = d1_quo_q[Q_W-1];
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = sq_valid_q[j-1];
      assign side_in = sq_side_q[j-1];
      assign rad_in  = sq_rad_q[j-1];
      assign rem_in  = sq_rem_q[j-1];
      assign root_in = sq_root_q[j-1];
    end

    assign cur   = {rem_in, rad_in[2*PI+1 -: 2]};
    assign trial = (ROOT_REM_W+2)'({root_in, 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[j] <= 1'b0;
      end else if (en) begin
        sq_valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_side_q[j] <= side_in;
        sq_rad_q[j]  <= rad_in;
        sq_rem_q[j]  <= take ? ROOT_REM_W'(cur - trial) : ROOT_REM_W'(cur);
        sq_root_q[j] <= {root_in[G_W-2:0], take};
      end
    end
  end

  // kg = ke * g / 2^24, then kg * dt in two partial products
  assign kg_prod = 61'(sq_side_q[G_W-1].ke) * 61'(sq_root_q[G_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
      m3_valid_q <= 1'b0;
      d0_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= sq_valid_q[G_W-1];
      m2_valid_q <= m1_valid_q;
      m3_valid_q <= m2_valid_q;
      d0_valid_q <= m3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_side_q <= sq_side_q[G_W-1];
      m1_kg_q   <= kg_prod[60:24];
      m2_side_q <= m1_side_q;
      m2_nlo_q  <= 64'(m1_kg_q[31:0]) * 64'(dt_q);
      m2_nhi_q  <= 37'(m1_kg_q[KG_W-1:32]) * 37'(dt_q);
      m3_side_q <= m2_side_q;
      m3_n_q    <= N_W'(m2_nlo_q) + {m2_nhi_q, 32'b0};
    end
  end

  // Quotient reaches 2^36 exactly when the upper dividend bits reach depth
  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_side_q <= m3_side_q;
      d0_sat_q  <= m3_n_q[N_W-1:QLO_W] >= 33'(m3_side_q.depth);
      d0_rem_q  <= m3_n_q[QLO_W+DEPTH_W-1:QLO_W];
      d0_low_q  <= m3_n_q[QLO_W-1:0];
    end
  end

  // Restoring division by depth for the low 36 quotient bits
  for (genvar k = 0; k < QLO_W; k++) begin : g_div2
    logic               v_in;
    side_t              side_in;
    logic               sat_in;
    logic [DEPTH_W-1:0] rem_in;
    logic [QLO_W-1:0]   low_in;
    logic [ALPHA_W-1:0] quo_in;
    logic [DEPTH_W:0]   trial;
    logic               take;

    if (k == 0) begin : g_first
      assign v_in    = d0_valid_q;
      assign side_in = d0_side_q;
      assign sat_in  = d0_sat_q;
      assign rem_in  = d0_rem_q;
      assign low_in  = d0_low_q;
      assign quo_in  = '0;
    end else begin : g_next
      assign v_in    = d2_valid_q[k-1];
      assign side_in = d2_side_q[k-1];
      assign sat_in  = d2_sat_q[k-1];
      assign rem_in  = d2_rem_q[k-1];
      assign low_in  = d2_low_q[k-1];
      assign quo_in  = d2_quo_q[k-1];
    end

    assign trial = {rem_in, low_in[QLO_W-1-k]};
    assign take  = trial >= {1'b0, side_in.depth};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d2_valid_q[k] <= 1'b0;
      end else if (en) begin
        d2_valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d2_side_q[k] <= side_in;
        d2_sat_q[k]  <= sat_in;
        d2_low_q[k]  <= low_in;
        d2_rem_q[k]  <= take ? DEPTH_W'(trial - {1'b0, side_in.depth}) : DEPTH_W'(trial);
        d2_quo_q[k]  <= {quo_in[ALPHA_W-2:0], take};
      end
    end
  end

  // Alpha saturates at 2^36 - 1
  assign st_valid[0]       = d2_valid_q[QLO_W-1];
  assign st_data[0].alpha  = d2_sat_q[QLO_W-1] ? '1 : d2_quo_q[QLO_W-1];
  assign st_data[0].target = d2_side_q[QLO_W-1].target;
  assign st_data[0].conc   = d2_side_q[QLO_W-1].conc;
  assign st_data[0].status = d2_side_q[QLO_W-1].status;

  // Unrolled substeps; those past the programmed count pass through
  for (genvar i = 0; i < NUM_SUBSTEPS; i++) begin : g_step
    asge_substep u_substep (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .active_i (cnt_q > 6'(i)),
      .valid_i  (st_valid[i]),
      .step_i   (st_data[i]),
      .valid_o  (st_valid[i+1]),
      .step_o   (st_data[i+1])
    );
  end

  assign out_valid_o         = st_valid[NUM_SUBSTEPS];
  assign new_concentration_o = st_data[NUM_SUBSTEPS].conc;
  assign status_o            = st_data[NUM_SUBSTEPS].status;

  // An accepted cell occupies the first stage on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted cell missing from first stage");

  // Schmidt division keeps its remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d1_valid_q[Q_W-1] && d1_side_q[Q_W-1].status == ST_UPDATED)
      |-> (d1_rem_q[Q_W-1] < d1_sc_q[Q_W-1]))
    else $error("Schmidt division remainder out of range");

  // Square root remainder never exceeds twice the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid_q[G_W-1] |-> (sq_rem_q[G_W-1] <= {1'b0, sq_root_q[G_W-1], 1'b0}))
    else $error("square root remainder out of range");

  // Depth division remainder stays below depth when not saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d2_valid_q[QLO_W-1] && d2_side_q[QLO_W-1].status == ST_UPDATED && !d2_sat_q[QLO_W-1])
      |-> (d2_rem_q[QLO_W-1] < d2_side_q[QLO_W-1].depth))
    else $error("depth division remainder out of range");

endmodule

@@ sv/asge_substep.sv @@
// One explicit Euler substep: difference stage, then scale and saturating update stage.
`timescale 1ns / 1ps
module asge_substep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            active_i,
  input  logic            valid_i,
  input  asge_pkg::step_t step_i,
  output logic            valid_o,
  output asge_pkg::step_t step_o
);
  import asge_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag_d;

  logic              valid_a_q;
  step_t             step_a_q;
  logic [DIFF_W-1:0] mag_a_q;
  logic              neg_a_q;
  logic              upd_a_q;

  logic [54:0]        prod_hi;
  logic [50:0]        prod_lo;
  logic [55:0]        sum;
  logic [38:0]        delta;
  logic signed [40:0] c_ext;
  logic signed [40:0] c_new;
  logic [31:0]        c_sat;
  step_t              step_d;

  // Distance to target and its magnitude
  assign diff  = $signed({2'b00, step_i.target}) - DIFF_W'($signed(step_i.conc));
  assign mag_d = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_a_q <= step_i;
      mag_a_q  <= mag_d;
      neg_a_q  <= diff[DIFF_W-1];
      upd_a_q  <= active_i && (step_i.status == ST_UPDATED);
    end
  end

  // alpha * |diff| / 2^32, alpha split at bit 16
  assign prod_hi = 55'(mag_a_q) * 55'(step_a_q.alpha[ALPHA_W-1:16]);
  assign prod_lo = 51'(mag_a_q) * 51'(step_a_q.alpha[15:0]);
  assign sum     = 56'(prod_hi) + 56'(prod_lo[50:16]);
  assign delta   = sum[54:16];

  // Move toward target and clamp to the signed 32-bit range
  assign c_ext = 41'($signed(step_a_q.conc));
  assign c_new = neg_a_q ? c_ext - $signed({2'b00, delta}) : c_ext + $signed({2'b00, delta});

  always_comb begin
    if (c_new > 41'sd2147483647) begin
      c_sat = 32'h7FFF_FFFF;
    end else if (c_new < -41'sd2147483648) begin
      c_sat = 32'h8000_0000;
    end else begin
      c_sat = c_new[31:0];
    end
    step_d = step_a_q;
    if (upd_a_q) begin
      step_d.conc = c_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_o <= step_d;
    end
  end

endmodule

@@ dv/tb_air_sea_gas_exchange_step.sv @@
// Testbench for the gas exchange step: directed and random cells against a bit-exact predictor.
`timescale 1ns / 1ps
module tb_air_sea_gas_exchange_step;
  import asge_pkg::*;

  localparam int LATENCY = 257;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        is_ocean_i = 1'b0;
  logic signed [31:0] concentration_i = '0;
  logic signed [14:0] temperature_i = '0;
  logic [30:0] saturation_i = '0;
  logic [16:0] ice_fraction_i = '0;
  logic [31:0] piston_velocity_i = '0;
  logic [17:0] air_pressure_i = '0;
  logic [23:0] layer_depth_top_i = '0;
  logic [23:0] layer_depth_second_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] new_concentration_o;
  logic [1:0]  status_o;

  typedef struct packed {
    logic        ocean;
    logic [31:0] conc;
    logic [14:0] temp;
    logic [30:0] sat;
    logic [16:0] ice;
    logic [31:0] kw;
    logic [17:0] pres;
    logic [23:0] d_top;
    logic [23:0] d_sec;
  } cell_t;

  typedef struct packed {
    logic [31:0] conc;
    status_e     status;
  } flux_res_t;

  air_sea_gas_exchange_step u_top (.*);

  // Predictor copy of the registers
  logic [31:0] a0_q, a1_q, a2_q, a3_q, dt_q;
  logic [5:0]  nsub_q;

  flux_res_t expected_q[$];
  int errors = 0;
  int hold_cycles = 0;     // forced receiver hold-off, counted down by the stall process
  bit hold_req = 1'b0;     // toggled to start a hold-off
  bit hold_ack = 1'b0;
  bit rand_stall = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Floor square root, bit by bit
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic flux_res_t predict_flux(input cell_t c);
    flux_res_t r;
    logic [63:0] tmag, t2, even, odd, q, g, ke, kg, qd, rd, alpha, target, ice, depth;
    logic [63:0] m, amax;
    logic signed [63:0] sc, cv, diff;
    tmag = c.temp[14] ? 64'(16'h8000 - {1'b0, c.temp}) : 64'(c.temp);
    depth = 64'(c.d_top);
    if (MIXED_LAYERS > 1) depth += 64'(c.d_sec);
    r.conc = c.conc;
    if (!c.ocean) begin
      r.status = ST_LAND;
      return r;
    end
    t2 = tmag * tmag;
    even = 64'(a0_q) + ((64'(a2_q) * t2) >> 16);
    odd = ((64'(a1_q) * tmag) >> 8) + ((((64'(a3_q) * t2) >> 16) * tmag) >> 8);
    sc = c.temp[14] ? $signed(even + odd) : $signed(even - odd);
    if (depth == 0 || sc <= 0) begin
      r.status = ST_INVALID;
      return r;
    end
    q = (64'd660 << 48) / 64'(sc);
    g = isqrt(q);
    ice = (c.ice > 17'd65536) ? 64'd65536 : 64'(c.ice);
    ke = ((64'd65536 - ice) * 64'(c.kw)) >> 16;
    kg = (ke * g) >> 24;
    qd = kg / depth;
    rd = kg % depth;
    amax = (64'd1 << 36) - 1;
    if (dt_q != 0 && qd > amax / 64'(dt_q)) alpha = amax;
    else begin
      alpha = qd * 64'(dt_q) + (rd * 64'(dt_q)) / depth;
      if (alpha > amax) alpha = amax;
    end
    target = (64'(c.sat) * 64'(c.pres)) >> 16;
    cv = $signed(64'($signed(c.conc)));
    for (int i = 0; i < nsub_q; i++) begin
      diff = $signed(target) - cv;
      m = diff >= 0 ? diff : -diff;
      m = ((m * (alpha >> 16)) + ((m * (alpha & 64'hFFFF)) >> 16)) >> 16;
      cv = diff >= 0 ? cv + $signed(m) : cv - $signed(m);
      if (cv > 64'sd2147483647) cv = 64'sd2147483647;
      if (cv < -64'sd2147483648) cv = -64'sd2147483648;
    end
    r.conc = cv[31:0];
    r.status = ST_UPDATED;
    return r;
  endfunction

  // Short gaps mostly, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_A0: a0_q = val;
      REG_A1: a1_q = val;
      REG_A2: a2_q = val;
      REG_A3: a3_q = val;
      REG_DT: dt_q = val;
      REG_COUNT: nsub_q = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] a0, a1, a2, a3, dt, input logic [5:0] n);
    write_reg(REG_A0, a0);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_A3, a3);
    write_reg(REG_DT, dt);
    write_reg(REG_COUNT, {26'd0, n});
  endtask

  // Wait until every expected result has come, then let the pipe drain
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Offer one cell and hold it until transferred
  task automatic send_cell(input cell_t c, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {is_ocean_i, concentration_i, temperature_i, saturation_i, ice_fraction_i,
     piston_velocity_i, air_pressure_i, layer_depth_top_i, layer_depth_second_i} <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_flux(c));
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Realistic-looking ocean cell with random content
  function automatic cell_t rand_cell();
    cell_t c;
    int p;
    c.ocean = ($urandom_range(9) != 0);
    c.conc = $urandom();
    c.temp = 15'($urandom_range(0, 10752)) - 15'd512;
    c.sat = 31'($urandom());
    c.ice = ($urandom_range(3) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536));
    c.kw = $urandom();
    c.pres = 18'($urandom());
    p = $urandom_range(9);
    c.d_top = (p == 0) ? 24'd0 : (p < 3) ? 24'($urandom()) : 24'($urandom_range(1, 40000));
    c.d_sec = (p == 0) ? 24'd0 : (p < 3) ? 24'($urandom()) : 24'($urandom_range(0, 40000));
    if ($urandom_range(19) == 0) c.temp = 15'($urandom());
    return c;
  endfunction

  // Typical seawater-like Schmidt coefficients with some spread
  task automatic rand_config();
    set_config(32'($urandom_range(1500, 2500)) << 16, 32'($urandom_range(80, 160)) << 16,
               32'($urandom_range(1, 5)) << 16, $urandom_range(0, 3000),
               $urandom_range(1, 600 * 256), 6'($urandom_range(1, 63)));
  endtask

  // Result checker
  always @(posedge clk_i) begin
    flux_res_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no cell outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (new_concentration_o !== e.conc) begin
          $error("new_concentration expected %h actual %h", e.conc, new_concentration_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          errors++;
        end
      end
    end
  end

  // Receiver stall: random, or a forced hold-off
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= 600;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (rand_stall) begin
      out_stall_i <= ($urandom_range(99) < 8) ? 1'b1 : ($urandom_range(99) < 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic test_reset_defaults();
    cell_t c;
    a0_q = 0; a1_q = 0; a2_q = 0; a3_q = 0; dt_q = 0; nsub_q = SUBSTEPS_RESET;
    // Sc is zero after reset: every ocean cell is invalid, land passes
    c = rand_cell(); c.ocean = 1'b1; send_cell(c, 0);
    c = rand_cell(); c.ocean = 1'b0; send_cell(c, 0);
    idle_input();
    drain();
  endtask

  task automatic test_directed();
    cell_t c;
    set_config(32'd2073 << 16, 32'd125 << 16, 32'd3 << 16, 32'd2000, 32'd300 << 8, 6'd30);
    c = '{1'b1, 32'h8000_0000, 15'd5120, 31'h7FFF_FFFF, 17'd0, 32'hFFFF_FFFF,
          18'h3FFFF, 24'hFFFFFF, 24'hFFFFFF};
    send_cell(c, 0);
    c.conc = 32'h7FFF_FFFF; c.sat = 31'd0; send_cell(c, 0);
    c.d_top = 24'd1; c.d_sec = 24'd0; send_cell(c, 0);           // large alpha
    c.d_top = 24'd0; send_cell(c, 0);                             // zero depth
    c.d_top = 24'd256; c.ice = 17'd65536; send_cell(c, 0);        // full ice
    c.ice = 17'h1FFFF; send_cell(c, 0);                           // ice above full
    c.ice = 17'd0; c.temp = 15'h7E00; send_cell(c, 0);            // negative temp
    c.temp = 15'd10240; send_cell(c, 0);                          // hot: Sc not positive
    c.ocean = 1'b0; send_cell(c, 0);                              // land
    c.ocean = 1'b1; c.temp = 15'h7FFF; c.conc = 32'd0; c.sat = 31'h1234567;
    c.pres = 18'h10000; send_cell(c, 0);
    idle_input();
    drain();
    // Extremes of the registers
    set_config(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 6'd63);
    c = rand_cell(); c.ocean = 1'b1; c.d_top = 24'd1; send_cell(c, 0);
    c.temp = 15'd0; send_cell(c, 0);                              // huge Sc
    c = rand_cell(); c.ocean = 1'b1; send_cell(c, 0);
    idle_input();
    drain();
    set_config(32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0, 6'd0);
    c = rand_cell(); c.ocean = 1'b1; c.temp = 15'd0; c.d_top = 24'd9; send_cell(c, 0);
    c.temp = 15'h7F00; send_cell(c, 0);
    c.temp = 15'd100; send_cell(c, 0);
    idle_input();
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_cell(rand_cell(), 1);
    idle_input();
  endtask

  task automatic test_backpressure();
    // Receiver holds off while the sender keeps offering
    hold_req = ~hold_req;
    test_random(450);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    rand_stall = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      rand_config();
      test_random(100);
      drain();       // sender pause until all results are in
    end
    rand_config();
    test_backpressure();
    rand_stall = 1'b0;
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
